// ----- sv/mtep_pkg.sv -----
// Shared types and constants for the MIDI track event parser.
// Used by the front end, event queue, back end and top level; no dependencies.
`default_nettype none

package mtep_pkg;

   // Result kinds
   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_HEADER  = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;

   // Status bytes with a meaning of their own
   localparam logic [7:0] STATUS_META   = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
   localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
   localparam logic [7:0] STATUS_FLAG   = 8'h80;

   // Channel message codes (upper status nibble)
   localparam logic [3:0] CODE_NOTE_ON  = 4'h9;
   localparam logic [3:0] CODE_NOTE_OFF = 4'h8;

   // Channel message lengths, status included
   localparam logic [27:0] LEN_ONE_DATA = 28'd2;
   localparam logic [27:0] LEN_TWO_DATA = 28'd3;

   // Variable-length quantity limit
   localparam int VLQ_MAX_BYTES = 4;

   // Event queue geometry
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Decoded event as passed from front end to back end.
   // data_a carries the first data byte, or the payload byte on payload kinds.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] ticks;
      logic [7:0]  status;
      logic [7:0]  data_a;
      logic [7:0]  data_b;
      logic [7:0]  meta_kind;
      logic [27:0] length;
      logic        last;
   } mtep_rec_type;

   // Queue status toward its producer and consumer
   typedef struct packed {
      logic full;
      logic not_empty;
   } mtep_qstat_type;

endpackage

`default_nettype wire

// ----- sv/midi_track_event_parser.sv -----
// MIDI track event parser: takes one track-body byte per cycle and returns
// decoded channel events, meta/sysex headers and payload bytes. Uses mtep_pkg.
//
// The block accepts one byte per clock cycle, sustained, as long as results
// are taken at the same pace; each byte updates the parse state in the front
// end. A result reaches the rsp_ port through a two-entry event queue and
// the output register. When rsp_ready is held low the queue fills and
// req_ready drops after two more results are waiting. Delta times and
// meta/sysex lengths are variable-length quantities of up to four bytes;
// absolute ticks wrap at 2^32 and are cleared by req_track_start.
`default_nettype none

module midi_track_event_parser
   import mtep_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_track_start,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [31:0]       rsp_abs_ticks,
   output logic [7:0]        rsp_status_byte,
   output logic [7:0]        rsp_event_code,
   output logic [3:0]        rsp_channel,
   output logic [7:0]        rsp_first_data,
   output logic [7:0]        rsp_second_data,
   output logic [7:0]        rsp_meta_kind,
   output logic [27:0]       rsp_length,
   output logic [7:0]        rsp_payload_byte,
   output logic              rsp_last
);

   logic           take;
   logic           push;
   logic           pop;
   mtep_rec_type   push_rec;
   mtep_rec_type   head_rec;
   mtep_qstat_type stat;

   assign req_ready = !stat.full;
   assign take      = req_valid && req_ready;

   mtep_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .data_byte   (req_data_byte),
      .track_start (req_track_start),
      .push        (push),
      .rec         (push_rec)
   );

   mtep_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .stat     (stat)
   );

   mtep_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_rec         (head_rec),
      .stat             (stat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_abs_ticks    (rsp_abs_ticks),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_event_code   (rsp_event_code),
      .rsp_channel      (rsp_channel),
      .rsp_first_data   (rsp_first_data),
      .rsp_second_data  (rsp_second_data),
      .rsp_meta_kind    (rsp_meta_kind),
      .rsp_length       (rsp_length),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

   // A decoded event never arrives at a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full)
      else $error("event pushed into full queue");

   // The byte that starts a track begins a delta time and never completes an event
   a_track_start_silent: assert property (@(posedge clock) disable iff (reset)
      (take && req_track_start) |-> !push)
      else $error("event produced on track start byte");

   // Channel events are always complete in one result
   a_channel_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_CHANNEL) |-> rsp_last)
      else $error("channel event without last mark");

   // A result leaves only through the output register after a queue pop
   a_valid_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pop))
      else $error("result valid without queue pop");

endmodule

`default_nettype wire

// ----- sv/mtep_front.sv -----
// Front end: accepts track bytes, walks delta times and event headers,
// keeps running status and the tick total, pushes decoded events. Uses mtep_pkg.
`default_nettype none

module mtep_front
   import mtep_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         take,
   input  wire logic [7:0]   data_byte,
   input  wire logic         track_start,
   output logic              push,
   output mtep_rec_type      rec
);

   typedef enum logic [2:0] {
      PH_DELTA,
      PH_STATUS,
      PH_DATA1,
      PH_DATA2,
      PH_MTYPE,
      PH_LEN,
      PH_PAYLOAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  running_ff, running_in;
   logic [31:0] tick_ff, tick_in;
   logic [27:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [7:0]  held_data_ff, held_data_in;
   logic [7:0]  held_meta_ff, held_meta_in;
   logic [7:0]  held_status_ff, held_status_in;
   logic [27:0] left_ff, left_in;

   // Channel event record
   function automatic mtep_rec_type chan_rec(input logic [7:0] st, input logic [31:0] tk,
                                             input logic [7:0] d1, input logic [7:0] d2,
                                             input logic two);
      mtep_rec_type r;
      r.kind      = KIND_CHANNEL;
      r.ticks     = tk;
      r.status    = st;
      r.data_a    = d1;
      r.data_b    = two ? d2 : 8'd0;
      r.meta_kind = 8'd0;
      r.length    = two ? LEN_TWO_DATA : LEN_ONE_DATA;
      r.last      = 1'b1;
      return r;
   endfunction

   // Next state and event decode
   always_comb begin
      phase_type   ph;
      logic [27:0] acc;
      logic [2:0]  cnt;
      logic [31:0] tick;
      logic [27:0] vlq_acc;
      logic [2:0]  vlq_cnt;
      logic        vlq_done;
      logic        one_data;
      logic [27:0] left_dec;

      phase_in       = phase_ff;
      running_in     = running_ff;
      tick_in        = tick_ff;
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      held_data_in   = held_data_ff;
      held_meta_in   = held_meta_ff;
      held_status_in = held_status_ff;
      left_in        = left_ff;
      push           = 1'b0;
      rec            = '0;

      // track start restarts the parse before the byte is taken
      ph   = track_start ? PH_DELTA : phase_ff;
      acc  = track_start ? 28'd0 : acc_ff;
      cnt  = track_start ? 3'd0 : cnt_ff;
      tick = track_start ? 32'd0 : tick_ff;

      vlq_acc  = {acc[20:0], data_byte[6:0]};
      vlq_cnt  = cnt + 3'd1;
      vlq_done = !data_byte[7] || (vlq_cnt >= 3'(VLQ_MAX_BYTES));
      one_data = running_ff inside {[8'hC0:8'hDF]};
      left_dec = left_ff - 28'd1;

      if (take) begin
         phase_in = ph;
         tick_in  = tick;
         acc_in   = acc;
         cnt_in   = cnt;
         case (ph)
            PH_STATUS: begin
               if (data_byte == STATUS_META) begin
                  held_status_in = data_byte;
                  phase_in       = PH_MTYPE;
               end else if (data_byte == STATUS_SYSEX || data_byte == STATUS_ESCAPE) begin
                  held_status_in = data_byte;
                  held_meta_in   = 8'd0;
                  acc_in         = 28'd0;
                  cnt_in         = 3'd0;
                  phase_in       = PH_LEN;
               end else if ((data_byte & STATUS_FLAG) != 8'd0) begin
                  running_in = data_byte;
                  phase_in   = PH_DATA1;
               end else if (one_data) begin
                  push     = 1'b1;
                  rec      = chan_rec(running_ff, tick, data_byte, 8'd0, 1'b0);
                  phase_in = PH_DELTA;
                  acc_in   = 28'd0;
                  cnt_in   = 3'd0;
               end else begin
                  held_data_in = data_byte;
                  phase_in     = PH_DATA2;
               end
            end
            PH_DATA1: begin
               if (one_data) begin
                  push     = 1'b1;
                  rec      = chan_rec(running_ff, tick, data_byte, 8'd0, 1'b0);
                  phase_in = PH_DELTA;
                  acc_in   = 28'd0;
                  cnt_in   = 3'd0;
               end else begin
                  held_data_in = data_byte;
                  phase_in     = PH_DATA2;
               end
            end
            PH_DATA2: begin
               push     = 1'b1;
               rec      = chan_rec(running_ff, tick, held_data_ff, data_byte, 1'b1);
               phase_in = PH_DELTA;
               acc_in   = 28'd0;
               cnt_in   = 3'd0;
            end
            PH_MTYPE: begin
               held_meta_in = data_byte;
               acc_in       = 28'd0;
               cnt_in       = 3'd0;
               phase_in     = PH_LEN;
            end
            PH_LEN: begin
               acc_in = vlq_acc;
               cnt_in = vlq_cnt;
               if (vlq_done) begin
                  left_in        = vlq_acc;
                  cnt_in         = 3'd0;
                  phase_in       = (vlq_acc != 28'd0) ? PH_PAYLOAD : PH_DELTA;
                  push           = 1'b1;
                  rec.kind       = KIND_HEADER;
                  rec.ticks      = tick;
                  rec.status     = held_status_ff;
                  rec.meta_kind  = held_meta_ff;
                  rec.length     = vlq_acc;
                  rec.last       = (vlq_acc == 28'd0);
               end
            end
            PH_PAYLOAD: begin
               left_in       = left_dec;
               push          = 1'b1;
               rec.kind      = KIND_PAYLOAD;
               rec.ticks     = tick;
               rec.status    = held_status_ff;
               rec.data_a    = data_byte;
               rec.meta_kind = held_meta_ff;
               rec.length    = acc;
               rec.last      = (left_dec == 28'd0);
               if (left_dec == 28'd0) begin
                  phase_in = PH_DELTA;
                  acc_in   = 28'd0;
                  cnt_in   = 3'd0;
               end
            end
            default: begin
               // delta time
               acc_in = vlq_acc;
               cnt_in = vlq_cnt;
               if (vlq_done) begin
                  tick_in  = tick + {4'd0, vlq_acc};
                  phase_in = PH_STATUS;
               end
            end
         endcase
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_DELTA;
         running_ff     <= 8'd0;
         tick_ff        <= 32'd0;
         acc_ff         <= 28'd0;
         cnt_ff         <= 3'd0;
         held_data_ff   <= 8'd0;
         held_meta_ff   <= 8'd0;
         held_status_ff <= 8'd0;
         left_ff        <= 28'd0;
      end else begin
         phase_ff       <= phase_in;
         running_ff     <= running_in;
         tick_ff        <= tick_in;
         acc_ff         <= acc_in;
         cnt_ff         <= cnt_in;
         held_data_ff   <= held_data_in;
         held_meta_ff   <= held_meta_in;
         held_status_ff <= held_status_in;
         left_ff        <= left_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/mtep_queue.sv -----
// Short event queue between front end and back end.
// Holds mtep_rec_type entries; uses mtep_pkg.
`default_nettype none

module mtep_queue
   import mtep_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire mtep_rec_type push_rec,
   input  wire logic         pop,
   output mtep_rec_type      head_rec,
   output mtep_qstat_type    stat
);

   mtep_rec_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign stat.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign head_rec       = mem_ff[rd_ptr_ff];

   // Pointer and fill update
   always_comb begin
      do_push   = push && !stat.full;
      do_pop    = pop && stat.not_empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

// ----- sv/mtep_back.sv -----
// Back end: takes queued events, forms the result fields and holds them
// in the output register until transferred. Uses mtep_pkg.
`default_nettype none

module mtep_back
   import mtep_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire mtep_rec_type   head_rec,
   input  wire mtep_qstat_type stat,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [31:0]         rsp_abs_ticks,
   output logic [7:0]          rsp_status_byte,
   output logic [7:0]          rsp_event_code,
   output logic [3:0]          rsp_channel,
   output logic [7:0]          rsp_first_data,
   output logic [7:0]          rsp_second_data,
   output logic [7:0]          rsp_meta_kind,
   output logic [27:0]         rsp_length,
   output logic [7:0]          rsp_payload_byte,
   output logic                rsp_last
);

   logic        valid_ff;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] ticks_ff;
   logic [7:0]  status_ff;
   logic [7:0]  code_ff, code_in;
   logic [3:0]  channel_ff, channel_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;
   logic [7:0]  meta_ff, meta_in;
   logic [27:0] length_ff;
   logic [7:0]  payload_ff, payload_in;
   logic        last_ff;

   // Load the output register when it is empty or being drained
   assign pop = stat.not_empty && (!valid_ff || rsp_ready);

   // Field formatting per kind
   always_comb begin
      logic [3:0] nib;
      nib        = head_rec.status[7:4];
      kind_in    = head_rec.kind;
      code_in    = head_rec.status;
      channel_in = 4'd0;
      first_in   = 8'd0;
      second_in  = 8'd0;
      meta_in    = head_rec.meta_kind;
      payload_in = 8'd0;
      case (head_rec.kind)
         KIND_CHANNEL: begin
            // note-on with zero velocity reads as note-off
            if (nib == CODE_NOTE_ON && head_rec.length == LEN_TWO_DATA
                && head_rec.data_b == 8'd0) begin
               code_in = {4'd0, CODE_NOTE_OFF};
            end else begin
               code_in = {4'd0, nib};
            end
            channel_in = head_rec.status[3:0];
            first_in   = head_rec.data_a;
            second_in  = head_rec.data_b;
            meta_in    = 8'd0;
         end
         KIND_PAYLOAD: begin
            payload_in = head_rec.data_a;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff    <= kind_in;
         ticks_ff   <= head_rec.ticks;
         status_ff  <= head_rec.status;
         code_ff    <= code_in;
         channel_ff <= channel_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         meta_ff    <= meta_in;
         length_ff  <= head_rec.length;
         payload_ff <= payload_in;
         last_ff    <= head_rec.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_abs_ticks    = ticks_ff;
   assign rsp_status_byte  = status_ff;
   assign rsp_event_code   = code_ff;
   assign rsp_channel      = channel_ff;
   assign rsp_first_data   = first_ff;
   assign rsp_second_data  = second_ff;
   assign rsp_meta_kind    = meta_ff;
   assign rsp_length       = length_ff;
   assign rsp_payload_byte = payload_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for midi_track_event_parser: drives track-body bytes,
// predicts every decoded result and compares it field by field.
// Depends on mtep_pkg and the midi_track_event_parser RTL.
`default_nettype none

module testbench
   import mtep_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_ITEMS      = 1650;
   localparam int WRAP_EVENTS  = 24;     // events with near-maximum deltas
   localparam int HOLD_AFTER   = 300;    // results before the long receiver stall
   localparam int HOLD_CYCLES  = 250;
   localparam int QUIET_FROM   = 800;    // accepted bytes: no idling in this stretch
   localparam int QUIET_TO     = 1100;
   localparam int SETTLE       = 20;     // pipeline is a two-entry queue plus the output register

   // Parse phases of the predictor
   typedef enum logic [2:0] {
      P_DELTA, P_STATUS, P_DATA1, P_DATA2, P_MTYPE, P_LEN, P_PAYLOAD
   } parse_phase_type;

   typedef struct {
      logic [7:0] data;
      logic       ts;
      logic       drain;   // hold this byte back until all results are in
   } track_byte_type;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] ticks;
      logic [7:0]  status;
      logic [7:0]  code;
      logic [3:0]  chan;
      logic [7:0]  d1;
      logic [7:0]  d2;
      logic [7:0]  mkind;
      logic [27:0] len;
      logic [7:0]  pay;
      logic        last;
   } event_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_track_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_abs_ticks;
   logic [7:0]  rsp_status_byte;
   logic [7:0]  rsp_event_code;
   logic [3:0]  rsp_channel;
   logic [7:0]  rsp_first_data;
   logic [7:0]  rsp_second_data;
   logic [7:0]  rsp_meta_kind;
   logic [27:0] rsp_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last;

   track_byte_type track_bytes[$];
   event_rec_type  decoded_events[$];
   event_rec_type  rsp_want;
   track_byte_type next_byte;

   int n_accepted = 0;
   int n_results  = 0;
   int n_errors   = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;
   logic quiet;

   assign quiet = (n_accepted >= QUIET_FROM) && (n_accepted < QUIET_TO);

   // Predictor state
   parse_phase_type ph = P_DELTA;
   logic [7:0]  run_status = 8'h00;
   logic [31:0] tick_sum = 32'd0;
   logic [27:0] vlq_acc = 28'd0;
   logic [2:0]  vlq_cnt = 3'd0;
   logic [7:0]  data_hold = 8'h00;
   logic [7:0]  meta_hold = 8'h00;
   logic [7:0]  status_hold = 8'h00;
   logic [27:0] pay_left = 28'd0;

   // Stimulus generator state
   logic [7:0] gen_status = 8'h00;
   logic       next_ts = 1'b0;
   logic       next_drain = 1'b0;

   midi_track_event_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_track_start  (req_track_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_abs_ticks    (rsp_abs_ticks),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_event_code   (rsp_event_code),
      .rsp_channel      (rsp_channel),
      .rsp_first_data   (rsp_first_data),
      .rsp_second_data  (rsp_second_data),
      .rsp_meta_kind    (rsp_meta_kind),
      .rsp_length       (rsp_length),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // Shift one byte into the variable-length value; 1 when complete
   function automatic bit vlq_shift(input logic [7:0] b);
      vlq_acc = {vlq_acc[20:0], b[6:0]};
      vlq_cnt = vlq_cnt + 3'd1;
      return !b[7] || (vlq_cnt >= VLQ_MAX_BYTES);
   endfunction

   function automatic bit single_data(input logic [7:0] st);
      return (st >= 8'hC0) && (st <= 8'hDF);
   endfunction

   function automatic void push_channel_event(input logic [7:0] d1, input logic [7:0] d2,
                                              input bit two);
      event_rec_type r;
      logic [3:0] code;
      code = run_status[7:4];
      if (two && code == CODE_NOTE_ON && d2 == 8'h00) code = CODE_NOTE_OFF;
      r.kind   = KIND_CHANNEL;
      r.ticks  = tick_sum;
      r.status = run_status;
      r.code   = {4'h0, code};
      r.chan   = run_status[3:0];
      r.d1     = d1;
      r.d2     = two ? d2 : 8'h00;
      r.mkind  = 8'h00;
      r.len    = two ? LEN_TWO_DATA : LEN_ONE_DATA;
      r.pay    = 8'h00;
      r.last   = 1'b1;
      decoded_events.push_back(r);
      ph = P_DELTA;
      vlq_acc = 28'd0;
      vlq_cnt = 3'd0;
   endfunction

   function automatic void push_meta_result(input logic [1:0] kind, input logic [7:0] pay,
                                            input bit last);
      event_rec_type r;
      r.kind   = kind;
      r.ticks  = tick_sum;
      r.status = status_hold;
      r.code   = status_hold;
      r.chan   = 4'h0;
      r.d1     = 8'h00;
      r.d2     = 8'h00;
      r.mkind  = meta_hold;
      r.len    = vlq_acc;
      r.pay    = pay;
      r.last   = last;
      decoded_events.push_back(r);
   endfunction

   // First data byte under the running status
   function automatic void take_first_data(input logic [7:0] b);
      if (single_data(run_status)) begin
         push_channel_event(b, 8'h00, 1'b0);
      end else begin
         data_hold = b;
         ph = P_DATA2;
      end
   endfunction

   // Advance the parse by one accepted byte
   function automatic void parse_byte(input logic [7:0] b, input logic ts);
      if (ts) begin
         tick_sum = 32'd0;
         ph = P_DELTA;
         vlq_acc = 28'd0;
         vlq_cnt = 3'd0;
      end
      case (ph)
         P_STATUS: begin
            if (b == STATUS_META) begin
               status_hold = b;
               ph = P_MTYPE;
            end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
               status_hold = b;
               meta_hold = 8'h00;
               vlq_acc = 28'd0;
               vlq_cnt = 3'd0;
               ph = P_LEN;
            end else if (b[7]) begin
               run_status = b;
               ph = P_DATA1;
            end else begin
               take_first_data(b);
            end
         end
         P_DATA1: take_first_data(b);
         P_DATA2: push_channel_event(data_hold, b, 1'b1);
         P_MTYPE: begin
            meta_hold = b;
            vlq_acc = 28'd0;
            vlq_cnt = 3'd0;
            ph = P_LEN;
         end
         P_LEN: begin
            if (vlq_shift(b)) begin
               pay_left = vlq_acc;
               ph = (pay_left != 28'd0) ? P_PAYLOAD : P_DELTA;
               vlq_cnt = 3'd0;
               push_meta_result(KIND_HEADER, 8'h00, pay_left == 28'd0);
            end
         end
         P_PAYLOAD: begin
            pay_left = pay_left - 28'd1;
            push_meta_result(KIND_PAYLOAD, b, pay_left == 28'd0);
            if (pay_left == 28'd0) begin
               ph = P_DELTA;
               vlq_acc = 28'd0;
               vlq_cnt = 3'd0;
            end
         end
         default: begin
            if (vlq_shift(b)) begin
               tick_sum = tick_sum + {4'h0, vlq_acc};
               ph = P_STATUS;
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------

   function automatic void add_byte(input logic [7:0] b);
      track_byte_type t;
      t.data  = b;
      t.ts    = next_ts;
      t.drain = next_drain;
      next_ts = 1'b0;
      next_drain = 1'b0;
      track_bytes.push_back(t);
   endfunction

   // Shortest variable-length encoding of v
   function automatic void add_vlq(input logic [27:0] v);
      int n;
      logic [27:0] grp;
      n = 1;
      while (n < 4 && (v >> (7 * n)) != 28'd0) n++;
      for (int i = n - 1; i >= 0; i--) begin
         grp = v >> (7 * i);
         add_byte({(i != 0), grp[6:0]});
      end
   endfunction

   function automatic void add_delta(input bit big);
      int sel;
      sel = $urandom_range(9);
      if (big) begin
         add_vlq(28'hFFFFFFF - 28'($urandom_range(255)));
      end else if (sel < 5) begin
         add_byte(8'($urandom_range(127)));
      end else if (sel < 7) begin
         add_vlq(28'($urandom_range(16383)));
      end else if (sel < 9) begin
         add_vlq(28'($urandom));
      end else begin
         // continuation flag on every byte: cut off after the fourth
         repeat (4) add_byte(8'h80 | 8'($urandom_range(127)));
      end
   endfunction

   function automatic void add_payload_event(input logic [7:0] st);
      int n;
      add_byte(st);
      if (st == STATUS_META) add_byte(8'($urandom_range(255)));
      n = ($urandom_range(9) < 8) ? $urandom_range(6) : $urandom_range(60, 7);
      add_vlq(28'(n));
      repeat (n) add_byte(8'($urandom_range(255)));
   endfunction

   function automatic void add_channel_event();
      logic [7:0] st;
      logic [7:0] d2;
      if (gen_status == 8'h00 || $urandom_range(2) == 0) begin
         if ($urandom_range(7) == 0) begin
            do st = 8'($urandom_range(254, 241)); while (st == STATUS_ESCAPE);
         end else begin
            st = 8'($urandom_range(239, 128));
         end
         add_byte(st);
         gen_status = st;
      end
      add_byte(8'($urandom_range(127)));
      if (!single_data(gen_status)) begin
         d2 = 8'($urandom_range(127));
         if (gen_status[7:4] == CODE_NOTE_ON && $urandom_range(3) == 0) d2 = 8'h00;
         add_byte(d2);
      end
   endfunction

   function automatic void add_event(input bit big);
      int sel;
      add_delta(big);
      sel = $urandom_range(9);
      if (big || sel < 6) add_channel_event();
      else if (sel < 8) add_payload_event(STATUS_META);
      else if (sel == 8) add_payload_event(STATUS_SYSEX);
      else add_payload_event(STATUS_ESCAPE);
   endfunction

   // Meta event with a huge length, cut short by a new track
   function automatic void add_cut_meta();
      add_delta(1'b0);
      add_byte(STATUS_META);
      add_byte(8'($urandom_range(255)));
      add_vlq($urandom_range(1) ? 28'hFFFFFFF : {1'b1, 27'($urandom)});
      repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255)));
      next_ts = 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Driver: one byte transfer per handshake
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_data_byte, req_track_start);
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (track_bytes.size() != 0
                && !(track_bytes[0].drain && decoded_events.size() != 0)
                && (quiet || $urandom_range(99) >= 29)) begin
               next_byte = track_bytes.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_byte.data;
               req_track_start <= next_byte.ts;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: check each result transfer against the oldest prediction
   // ---------------------------------------------------------------
   function automatic void compare(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         n_errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (decoded_events.size() == 0) begin
               $error("result transfer with no prediction pending (kind %0d)", rsp_kind);
               n_errors++;
            end else begin
               rsp_want = decoded_events.pop_front();
               compare("kind",         32'(rsp_want.kind),   32'(rsp_kind));
               compare("abs_ticks",    rsp_want.ticks,       rsp_abs_ticks);
               compare("status_byte",  32'(rsp_want.status), 32'(rsp_status_byte));
               compare("event_code",   32'(rsp_want.code),   32'(rsp_event_code));
               compare("channel",      32'(rsp_want.chan),   32'(rsp_channel));
               compare("first_data",   32'(rsp_want.d1),     32'(rsp_first_data));
               compare("second_data",  32'(rsp_want.d2),     32'(rsp_second_data));
               compare("meta_kind",    32'(rsp_want.mkind),  32'(rsp_meta_kind));
               compare("length",       32'(rsp_want.len),    32'(rsp_length));
               compare("payload_byte", 32'(rsp_want.pay),    32'(rsp_payload_byte));
               compare("last",         32'(rsp_want.last),   32'(rsp_last));
            end
         end
         // one long stall so the queue fills and input backs up
         if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 29);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------
   initial begin
      int sel;
      bit drain_set;
      drain_set = 1'b0;

      // data bytes before any status: running status zero, two data bytes
      next_ts = 1'b1;
      add_byte(8'h00); add_byte(8'h12); add_byte(8'h34);
      // note-on with zero velocity reads as note-off
      add_byte(8'h00); add_byte(8'h90); add_byte(8'h3C); add_byte(8'h00);
      // four-byte delta with the continuation bit still set, then running status
      add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF);
      add_byte(8'h3C); add_byte(8'h7F);
      // program change: one data byte
      add_byte(8'h00); add_byte(8'hC5); add_byte(8'h10);
      // empty meta event: header alone carries last
      add_byte(8'h00); add_byte(STATUS_META); add_byte(8'h2F); add_byte(8'h00);
      // escape sysex with one payload byte
      add_byte(8'h00); add_byte(STATUS_ESCAPE); add_byte(8'h01); add_byte(8'hAA);
      // system status treated as a two-byte channel status, dropped by a new track
      add_byte(8'h00); add_byte(8'hF5); add_byte(8'h01);
      next_ts = 1'b1;

      // run the tick total past 2^32 within one track
      repeat (WRAP_EVENTS) add_event(1'b1);

      while (track_bytes.size() < N_ITEMS) begin
         sel = $urandom_range(99);
         if (sel < 2) begin
            repeat ($urandom_range(6, 1)) add_byte(8'($urandom_range(255)));
            next_ts = 1'b1;
         end else if (sel < 4) begin
            add_cut_meta();
         end else begin
            if ($urandom_range(49) == 0) next_ts = 1'b1;
            add_event(1'b0);
         end
         if (!drain_set && track_bytes.size() > (N_ITEMS * 2) / 3) begin
            next_drain = 1'b1;
            drain_set = 1'b1;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (track_bytes.size() != 0 || req_valid) @(posedge clock);
      while (decoded_events.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (n_errors == 0 && decoded_events.size() == 0) begin
         $display("midi_track_event_parser test passed");
      end else begin
         $display("midi_track_event_parser test failed");
      end
      $finish;
   end

   // Watchdog: fails a run that does not finish
   initial begin
      #2_000_000;
      $display("midi_track_event_parser test failed");
      $finish;
   end

endmodule

`default_nettype wire
